// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the steering controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/wfps_pkg.sv =====
// Package with types and constants of the wall-following steering controller.
package wfps_pkg;

  // Default sizes.
  localparam int DIST_WIDTH_DEF = 16;
  localparam int SUM_WIDTH_DEF  = 32;

  // Fixed field widths.
  localparam int GAIN_WIDTH      = 16;
  localparam int PID_WIDTH       = 16;
  localparam int LIN_WIDTH       = 8;
  localparam int CFG_INDEX_WIDTH = 3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TARGET     = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PROP_GAIN  = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INT_GAIN   = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_DER_GAIN   = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOST_THR   = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_NEAR_THR   = 3'd5;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_FOLLOW_FLR = 3'd6;

  // Register values after reset.
  localparam int RST_TARGET     = 328;
  localparam int RST_PROP_GAIN  = 4588;
  localparam int RST_INT_GAIN   = 33;
  localparam int RST_DER_GAIN   = 3277;
  localparam int RST_LOST_THR   = 369;
  localparam int RST_NEAR_THR   = 287;
  localparam int RST_FOLLOW_FLR = 266;

  // Drive modes.
  typedef enum logic [1:0] {
    MODE_LOST   = 2'd0,
    MODE_FOLLOW = 2'd1,
    MODE_RIGHT  = 2'd2,
    MODE_FAST   = 2'd3
  } drive_mode_t;

  // Fixed speeds: forward speeds in unsigned Q0.8, turn rates in signed Q4.12.
  localparam logic [LIN_WIDTH-1:0] SPEED_CRUISE = 8'd164;
  localparam logic [LIN_WIDTH-1:0] SPEED_CREEP  = 8'd41;
  localparam logic [LIN_WIDTH-1:0] SPEED_STOP   = 8'd0;
  localparam logic signed [PID_WIDTH-1:0] TURN_LOST = 16'sd1229;
  localparam logic signed [PID_WIDTH-1:0] TURN_FAST = -16'sd6144;
  localparam logic signed [PID_WIDTH-1:0] PID_MAX   = 16'sd32767;
  localparam logic signed [PID_WIDTH-1:0] PID_MIN   = -16'sd32768;

  // Load strobes for the PID pipeline stages.
  typedef struct packed {
    logic ld_b;
    logic ld_c;
  } stage_ld_t;

endpackage

// ===== hw/rtl/wfps_pid_core.sv =====
// PID datapath: error and saturating sum stage, product stage, rounding and saturation.
module wfps_pid_core #(
  parameter int DIST_WIDTH = wfps_pkg::DIST_WIDTH_DEF,
  parameter int SUM_WIDTH  = wfps_pkg::SUM_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  wfps_pkg::stage_ld_t                   stage_ld,
  input  logic [DIST_WIDTH-1:0]                 target,
  input  logic [wfps_pkg::GAIN_WIDTH-1:0]       prop_gain,
  input  logic [wfps_pkg::GAIN_WIDTH-1:0]       integral_gain,
  input  logic [wfps_pkg::GAIN_WIDTH-1:0]       derivative_gain,
  input  logic [DIST_WIDTH-1:0]                 left_dist,
  output logic signed [wfps_pkg::PID_WIDTH-1:0] pid
);
  import wfps_pkg::*;
  `include "assert_macros.svh"

  localparam int ERR_W  = DIST_WIDTH + 1;
  localparam int DIFF_W = DIST_WIDTH + 2;
  localparam int SX_W   = (SUM_WIDTH > ERR_W ? SUM_WIDTH : ERR_W) + 1;
  localparam int GS_W   = GAIN_WIDTH + 1;
  localparam int PP_W   = GS_W + ERR_W;
  localparam int PI_W   = GS_W + SUM_WIDTH;
  localparam int PD_W   = GS_W + DIFF_W;
  localparam int ACC_W  = (SUM_WIDTH > DIFF_W ? SUM_WIDTH : DIFF_W) + GS_W + 2;
  localparam int SH_W   = ACC_W - 16;

  localparam logic signed [SX_W-1:0] SUM_MAX =
    {{(SX_W - SUM_WIDTH + 1){1'b0}}, {(SUM_WIDTH - 1){1'b1}}};
  localparam logic signed [SX_W-1:0] SUM_MIN = ~SUM_MAX;
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

  // Stage B state: the last error and the running sum double as stage registers.
  logic signed [ERR_W-1:0]     last_error_r;
  logic signed [SUM_WIDTH-1:0] error_sum_r;
  logic signed [DIFF_W-1:0]    diff_r;

  // Stage C products.
  logic signed [PP_W-1:0] prod_p_r;
  logic signed [PI_W-1:0] prod_i_r;
  logic signed [PD_W-1:0] prod_d_r;

  logic signed [ERR_W-1:0]     err;
  logic signed [SX_W-1:0]      sum_wide;
  logic signed [SUM_WIDTH-1:0] error_sum_nxt;
  logic signed [DIFF_W-1:0]    diff_nxt;
  logic signed [PP_W-1:0]      prod_p_nxt;
  logic signed [PI_W-1:0]      prod_i_nxt;
  logic signed [PD_W-1:0]      prod_d_nxt;
  logic signed [ACC_W-1:0]     acc;
  logic signed [SH_W-1:0]      acc_q12;

  // Error, saturating accumulation and difference.
  always_comb begin
    err      = $signed({1'b0, target}) - $signed({1'b0, left_dist});
    sum_wide = SX_W'(error_sum_r) + SX_W'(err);
    if (sum_wide > SUM_MAX) begin
      error_sum_nxt = SUM_MAX[SUM_WIDTH-1:0];
    end else if (sum_wide < SUM_MIN) begin
      error_sum_nxt = SUM_MIN[SUM_WIDTH-1:0];
    end else begin
      error_sum_nxt = sum_wide[SUM_WIDTH-1:0];
    end
    diff_nxt = DIFF_W'(err) - DIFF_W'(last_error_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_error_r <= '0;
      error_sum_r  <= '0;
    end else if (stage_ld.ld_b) begin
      last_error_r <= err;
      error_sum_r  <= error_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ld.ld_b) begin
      diff_r <= diff_nxt;
    end
  end

  // Three independent gain products on the stage B values.
  assign prod_p_nxt = $signed({1'b0, prop_gain}) * last_error_r;
  assign prod_i_nxt = $signed({1'b0, integral_gain}) * error_sum_r;
  assign prod_d_nxt = $signed({1'b0, derivative_gain}) * diff_r;

  always_ff @(posedge clk) begin
    if (stage_ld.ld_c) begin
      prod_p_r <= prod_p_nxt;
      prod_i_r <= prod_i_nxt;
      prod_d_r <= prod_d_nxt;
    end
  end

  // Sum, round half up to Q.12 and saturate to 16 bits.
  always_comb begin
    acc     = ACC_W'(prod_p_r) + ACC_W'(prod_i_r) + ACC_W'(prod_d_r) + ROUND_HALF;
    acc_q12 = SH_W'(acc >>> 16);
    if (acc_q12 > SH_W'(PID_MAX)) begin
      pid = PID_MAX;
    end else if (acc_q12 < SH_W'(PID_MIN)) begin
      pid = PID_MIN;
    end else begin
      pid = acc_q12[PID_WIDTH-1:0];
    end
  end

  // The controller state moves only when a request enters stage B.
  `ASSERT_NEXT(a_sum_hold, !stage_ld.ld_b, $stable(error_sum_r),
    "error sum changed without a request entering stage B")
  `ASSERT_NEXT(a_err_hold, !stage_ld.ld_b, $stable(last_error_r),
    "last error changed without a request entering stage B")
  `ASSERT_NEXT(a_diff_link, stage_ld.ld_b,
    diff_r == DIFF_W'(last_error_r) - DIFF_W'($past(last_error_r)),
    "difference does not match the error step")

endmodule

// ===== hw/rtl/wall_follow_pid_steering.sv =====
// Top level of the wall-following PID steering controller.
//
// Requests carry the left, front and right wall distances (unsigned Q4.12 m)
// on in_range_*, with in_valid and in_stall. Each request gives exactly one
// result on out_drive_mode, out_fwd_speed and out_turn_rate, with
// out_valid and out_stall, in request order.
// The datapath is four register stages: input register, error and sum stage,
// product stage and result register. One request can be accepted every cycle
// while in_stall is low. The error sum and last error update as a request
// enters the second stage, a single add and saturate for each request.
// When the receiver stalls, the result register holds its value and the
// stages behind it fill; in_stall rises once every stage is occupied.
// Reset (rst_n low, synchronous) empties the pipeline, clears the error sum
// and last error, and loads the configuration registers with their defaults.
// Configuration writes through cfg_we, cfg_index and cfg_wdata take effect at
// the next clock edge. The user must make them only while no request is in
// flight; the block itself does not enforce this.
module wall_follow_pid_steering #(
  parameter int DIST_WIDTH = wfps_pkg::DIST_WIDTH_DEF,
  parameter int SUM_WIDTH  = wfps_pkg::SUM_WIDTH_DEF,
  parameter int CFG_WIDTH  = (DIST_WIDTH > wfps_pkg::GAIN_WIDTH) ? DIST_WIDTH
                                                                  : wfps_pkg::GAIN_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [wfps_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [CFG_WIDTH-1:0]                  cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [DIST_WIDTH-1:0]                 in_range_left,
  input  logic [DIST_WIDTH-1:0]                 in_range_front,
  input  logic [DIST_WIDTH-1:0]                 in_range_right,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            out_drive_mode,
  output logic [wfps_pkg::LIN_WIDTH-1:0]        out_fwd_speed,
  output logic signed [wfps_pkg::PID_WIDTH-1:0] out_turn_rate
);
  import wfps_pkg::*;
  `include "assert_macros.svh"

  // Configuration registers.
  logic [DIST_WIDTH-1:0] target_r;
  logic [GAIN_WIDTH-1:0] prop_gain_r;
  logic [GAIN_WIDTH-1:0] int_gain_r;
  logic [GAIN_WIDTH-1:0] der_gain_r;
  logic [DIST_WIDTH-1:0] lost_thr_r;
  logic [DIST_WIDTH-1:0] near_thr_r;
  logic [DIST_WIDTH-1:0] follow_flr_r;

  // Pipeline valid bits and payload.
  logic                  a_valid_r;
  logic                  b_valid_r;
  logic                  c_valid_r;
  logic                  out_valid_r;
  logic [DIST_WIDTH-1:0] left_a_r;
  logic [DIST_WIDTH-1:0] front_a_r;
  logic [DIST_WIDTH-1:0] right_a_r;
  drive_mode_t           mode_b_r;
  drive_mode_t           mode_c_r;
  drive_mode_t           out_mode_r;
  logic [LIN_WIDTH-1:0]  out_linear_r;
  logic signed [PID_WIDTH-1:0] out_angular_r;

  logic rdy_a, rdy_b, rdy_c, rdy_out;
  logic accept_in, ld_out;
  stage_ld_t stage_ld;

  logic [DIST_WIDTH-1:0]       nearest;
  drive_mode_t                 mode_nxt;
  logic signed [PID_WIDTH-1:0] pid;
  logic signed [PID_WIDTH-1:0] pid_neg;
  logic [LIN_WIDTH-1:0]        out_linear_nxt;
  logic signed [PID_WIDTH-1:0] out_angular_nxt;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r     <= DIST_WIDTH'(RST_TARGET);
      prop_gain_r  <= GAIN_WIDTH'(RST_PROP_GAIN);
      int_gain_r   <= GAIN_WIDTH'(RST_INT_GAIN);
      der_gain_r   <= GAIN_WIDTH'(RST_DER_GAIN);
      lost_thr_r   <= DIST_WIDTH'(RST_LOST_THR);
      near_thr_r   <= DIST_WIDTH'(RST_NEAR_THR);
      follow_flr_r <= DIST_WIDTH'(RST_FOLLOW_FLR);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET:     target_r     <= cfg_wdata[DIST_WIDTH-1:0];
        REG_PROP_GAIN:  prop_gain_r  <= cfg_wdata[GAIN_WIDTH-1:0];
        REG_INT_GAIN:   int_gain_r   <= cfg_wdata[GAIN_WIDTH-1:0];
        REG_DER_GAIN:   der_gain_r   <= cfg_wdata[GAIN_WIDTH-1:0];
        REG_LOST_THR:   lost_thr_r   <= cfg_wdata[DIST_WIDTH-1:0];
        REG_NEAR_THR:   near_thr_r   <= cfg_wdata[DIST_WIDTH-1:0];
        REG_FOLLOW_FLR: follow_flr_r <= cfg_wdata[DIST_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // Flow control: a stage loads when it is empty or its content moves on.
  always_comb begin
    rdy_out        = !out_valid_r || !out_stall;
    ld_out         = c_valid_r && rdy_out;
    rdy_c          = !c_valid_r || rdy_out;
    stage_ld.ld_c  = b_valid_r && rdy_c;
    rdy_b          = !b_valid_r || rdy_c;
    stage_ld.ld_b  = a_valid_r && rdy_b;
    rdy_a          = !a_valid_r || rdy_b;
    accept_in      = in_valid && rdy_a;
  end

  assign in_stall = !rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= accept_in || (a_valid_r && !stage_ld.ld_b);
      b_valid_r   <= stage_ld.ld_b || (b_valid_r && !stage_ld.ld_c);
      c_valid_r   <= stage_ld.ld_c || (c_valid_r && !ld_out);
      out_valid_r <= ld_out || (out_valid_r && out_stall);
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (accept_in) begin
      left_a_r  <= in_range_left;
      front_a_r <= in_range_front;
      right_a_r <= in_range_right;
    end
  end

  // Mode decision from the nearest wall and the front and left distances.
  always_comb begin
    nearest = (left_a_r < front_a_r) ? left_a_r : front_a_r;
    if (right_a_r < nearest) begin
      nearest = right_a_r;
    end
    if (nearest > lost_thr_r) begin
      mode_nxt = MODE_LOST;
    end else if (front_a_r <= near_thr_r) begin
      mode_nxt = MODE_FAST;
    end else if (front_a_r <= lost_thr_r || left_a_r < near_thr_r) begin
      mode_nxt = MODE_RIGHT;
    end else if (nearest <= near_thr_r && nearest > follow_flr_r) begin
      mode_nxt = MODE_FOLLOW;
    end else begin
      mode_nxt = MODE_LOST;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_ld.ld_b) begin
      mode_b_r <= mode_nxt;
    end
    if (stage_ld.ld_c) begin
      mode_c_r <= mode_b_r;
    end
  end

  wfps_pid_core #(
    .DIST_WIDTH (DIST_WIDTH),
    .SUM_WIDTH  (SUM_WIDTH)
  ) u_pid (
    .clk             (clk),
    .rst_n           (rst_n),
    .stage_ld        (stage_ld),
    .target          (target_r),
    .prop_gain       (prop_gain_r),
    .integral_gain   (int_gain_r),
    .derivative_gain (der_gain_r),
    .left_dist       (left_a_r),
    .pid             (pid)
  );

  // Speed selection; negating the most negative PID output saturates to the maximum.
  always_comb begin
    pid_neg = (pid == PID_MIN) ? PID_MAX : -pid;
    case (mode_c_r)
      MODE_FOLLOW: begin
        out_linear_nxt  = SPEED_CRUISE;
        out_angular_nxt = pid;
      end
      MODE_RIGHT: begin
        out_linear_nxt  = SPEED_CREEP;
        out_angular_nxt = pid_neg;
      end
      MODE_FAST: begin
        out_linear_nxt  = SPEED_STOP;
        out_angular_nxt = TURN_FAST;
      end
      default: begin
        out_linear_nxt  = SPEED_CRUISE;
        out_angular_nxt = TURN_LOST;
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_mode_r    <= mode_c_r;
      out_linear_r  <= out_linear_nxt;
      out_angular_r <= out_angular_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_drive_mode = out_mode_r;
  assign out_fwd_speed  = out_linear_r;
  assign out_turn_rate  = out_angular_r;

  // A blocked stage keeps its request; fast-turn and lost results carry fixed speeds.
  `ASSERT_NEXT(a_hold_a, a_valid_r && !rdy_b, a_valid_r,
    "input stage dropped a blocked request")
  `ASSERT_NEXT(a_hold_c, c_valid_r && !rdy_out, c_valid_r && $stable(mode_c_r),
    "product stage lost a blocked request")
  `ASSERT_IMPLY(a_fast_stop, out_valid_r && out_mode_r == MODE_FAST,
    out_linear_r == SPEED_STOP && out_angular_r == TURN_FAST,
    "fast right turn result with wrong speeds")
  `ASSERT_IMPLY(a_lost_speeds, out_valid_r && out_mode_r == MODE_LOST,
    out_linear_r == SPEED_CRUISE && out_angular_r == TURN_LOST,
    "lost mode result with wrong speeds")

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the wall-following PID steering controller.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wfps_pkg::*;

  // Index beyond the register list; a write there must change nothing.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE = 3'd7;

  localparam logic signed [31:0] SUM_CEIL  = 32'sh7fff_ffff;
  localparam logic signed [31:0] SUM_FLOOR = 32'sh8000_0000;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 40;

  // One steering command as the block returns it.
  typedef struct packed {
    drive_mode_t       mode;
    logic [7:0]        speed;
    logic signed [15:0] turn;
  } steer_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  // One line of the directed table: a register write or a request.
  typedef struct packed {
    row_kind_t   kind;
    logic [2:0]  idx;
    logic [15:0] wdata;
    logic [15:0] left;
    logic [15:0] front;
    logic [15:0] right;
    logic        typed;
    steer_t      want;
  } plan_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] in_range_left = '0;
  logic [15:0] in_range_front = '0;
  logic [15:0] in_range_right = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_drive_mode;
  logic [LIN_WIDTH-1:0] out_fwd_speed;
  logic signed [PID_WIDTH-1:0] out_turn_rate;

  // Shadow of the controller: registers, PID state and pending commands.
  logic [15:0] cfg_shadow [0:6];
  logic signed [16:0] last_err_q = '0;
  logic signed [31:0] err_sum_q = '0;
  steer_t pending_steer [$];

  bit calm_tail = 1'b0;
  int tx_gap_pct = 30;
  int rx_left = 0;
  int idle_cycles = 0;
  int n_fail = 0;

  wall_follow_pid_steering i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_range_left(in_range_left),
    .in_range_front(in_range_front),
    .in_range_right(in_range_right),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_drive_mode(out_drive_mode),
    .out_fwd_speed(out_fwd_speed),
    .out_turn_rate(out_turn_rate)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint clamp_turn(longint v);
    if (v > longint'(PID_MAX)) return longint'(PID_MAX);
    if (v < longint'(PID_MIN)) return longint'(PID_MIN);
    return v;
  endfunction

  // Advance the PID state by one tick and work out the steering command.
  function automatic steer_t compute_steering(logic [15:0] left, logic [15:0] front,
                                              logic [15:0] right);
    longint err, diff, sum, acc, pid;
    logic [15:0] nearest;
    steer_t res;
    err = longint'(cfg_shadow[REG_TARGET]) - longint'(left);
    sum = longint'(err_sum_q) + err;
    if (sum > longint'(SUM_CEIL)) sum = longint'(SUM_CEIL);
    if (sum < longint'(SUM_FLOOR)) sum = longint'(SUM_FLOOR);
    diff = err - longint'(last_err_q);
    acc = longint'(cfg_shadow[REG_PROP_GAIN]) * err
        + longint'(cfg_shadow[REG_INT_GAIN]) * sum
        + longint'(cfg_shadow[REG_DER_GAIN]) * diff + 64'sd32768;
    // Arithmetic shift floors, so adding half first rounds half up.
    pid = clamp_turn(acc >>> 16);
    err_sum_q = sum[31:0];
    last_err_q = err[16:0];

    nearest = left;
    if (front < nearest) nearest = front;
    if (right < nearest) nearest = right;

    // Mode priority: lost, fast turn, turn, follow, and lost when no band fits.
    if (nearest > cfg_shadow[REG_LOST_THR]) res.mode = MODE_LOST;
    else if (front <= cfg_shadow[REG_NEAR_THR]) res.mode = MODE_FAST;
    else if (front <= cfg_shadow[REG_LOST_THR] || left < cfg_shadow[REG_NEAR_THR])
      res.mode = MODE_RIGHT;
    else if (nearest <= cfg_shadow[REG_NEAR_THR] && nearest > cfg_shadow[REG_FOLLOW_FLR])
      res.mode = MODE_FOLLOW;
    else res.mode = MODE_LOST;

    case (res.mode)
      MODE_FOLLOW: begin
        res.speed = SPEED_CRUISE;
        res.turn = pid[15:0];
      end
      MODE_RIGHT: begin
        res.speed = SPEED_CREEP;
        res.turn = 16'(clamp_turn(-pid));
      end
      MODE_FAST: begin
        res.speed = SPEED_STOP;
        res.turn = TURN_FAST;
      end
      default: begin
        res.speed = SPEED_CRUISE;
        res.turn = TURN_LOST;
      end
    endcase
    return res;
  endfunction

  function automatic plan_row_t tick_row(logic [15:0] l, logic [15:0] f, logic [15:0] r);
    plan_row_t row;
    row = '0;
    row.kind = ROW_TICK;
    row.left = l;
    row.front = f;
    row.right = r;
    return row;
  endfunction

  function automatic plan_row_t fixed_row(logic [15:0] l, logic [15:0] f, logic [15:0] r,
                                          drive_mode_t m, logic [7:0] spd,
                                          logic signed [15:0] trn);
    plan_row_t row;
    row = tick_row(l, f, r);
    row.typed = 1'b1;
    row.want.mode = m;
    row.want.speed = spd;
    row.want.turn = trn;
    return row;
  endfunction

  function automatic plan_row_t wr_row(logic [2:0] idx, logic [15:0] val);
    plan_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.idx = idx;
    row.wdata = val;
    return row;
  endfunction

  // Mostly everyday values, sometimes the extremes or any word at all.
  function automatic logic [15:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 6000));
    endcase
  endfunction

  // Distances cluster around the thresholds so that every mode boundary is hit.
  function automatic logic [15:0] pick_dist();
    logic [15:0] base;
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hffff;
      2, 3: return 16'($urandom);
      4: base = cfg_shadow[REG_LOST_THR];
      5: base = cfg_shadow[REG_NEAR_THR];
      6: base = cfg_shadow[REG_FOLLOW_FLR];
      7: base = cfg_shadow[REG_TARGET];
      default: return 16'($urandom_range(0, 2 * cfg_shadow[REG_LOST_THR] + 64));
    endcase
    return base + 16'($urandom_range(0, 6)) - 16'd3;
  endfunction

  // Present one request and hold it until the block takes it.
  task automatic send_tick(logic [15:0] left, logic [15:0] front, logic [15:0] right,
                           logic typed, steer_t fixed_res);
    steer_t res;
    in_valid <= 1'b1;
    in_range_left <= left;
    in_range_front <= front;
    in_range_right <= right;
    do @(posedge clk); while (in_stall !== 1'b0);
    res = compute_steering(left, front, right);
    pending_steer.push_back(typed ? fixed_res : res);
    if (!calm_tail && $urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_steer.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx <= REG_FOLLOW_FLR) cfg_shadow[idx] = val;
    @(posedge clk);
  endtask

  // New settings for a random block; thresholds are usually ordered, sometimes not.
  task automatic retune();
    logic [15:0] flr, nr, lst;
    flr = 16'($urandom_range(100, 400));
    nr = flr + 16'($urandom_range(0, 200));
    lst = nr + 16'($urandom_range(0, 200));
    if ($urandom_range(0, 4) == 0) begin
      flr = rand_word();
      nr = rand_word();
      lst = rand_word();
    end
    wait_idle();
    write_reg(REG_TARGET, ($urandom_range(0, 3) == 0) ? rand_word()
                                                       : 16'($urandom_range(200, 460)));
    write_reg(REG_PROP_GAIN, rand_word());
    write_reg(REG_INT_GAIN, rand_word());
    write_reg(REG_DER_GAIN, rand_word());
    write_reg(REG_LOST_THR, lst);
    write_reg(REG_NEAR_THR, nr);
    write_reg(REG_FOLLOW_FLR, flr);
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, 16'($urandom));
  endtask

  task automatic report_bad(string what, logic signed [16:0] want_v,
                            logic signed [16:0] got_v);
    n_fail++;
    if (n_fail <= MAX_REPORTS)
      $display("%0t: %s expected %0d, got %0d", $time, what, want_v, got_v);
  endtask

  // Result checker: every accepted result against the oldest pending command.
  always @(posedge clk) begin : check_result
    steer_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_steer.size() == 0) begin
        n_fail++;
        if (n_fail <= MAX_REPORTS)
          $display("%0t: result with no request pending, mode %0d", $time, out_drive_mode);
      end else begin
        want = pending_steer.pop_front();
        if (out_drive_mode !== want.mode)
          report_bad("drive_mode", 17'(want.mode), 17'(out_drive_mode));
        if (out_fwd_speed !== want.speed)
          report_bad("fwd_speed", 17'(want.speed), 17'(out_fwd_speed));
        if (out_turn_rate !== want.turn)
          report_bad("turn_rate", 17'(want.turn), 17'(out_turn_rate));
      end
    end
  end

  // Receiver: random stall bursts between free-running stretches.
  always @(posedge clk) begin
    if (!rst_n || calm_tail) begin
      out_stall <= 1'b0;
      rx_left = 0;
    end else if (rx_left == 0) begin
      if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        rx_left = $urandom_range(0, 14);
      end else begin
        out_stall <= 1'b0;
        rx_left = $urandom_range(0, 39);
      end
    end else begin
      rx_left--;
    end
  end

  // Watchdog: too long without any request or result moving ends the run.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus: directed table, random blocks, then a back-to-back tail.
  initial begin
    plan_row_t plan [$];
    logic [15:0] left_d, front_d, right_d;

    cfg_shadow[REG_TARGET] = 16'(RST_TARGET);
    cfg_shadow[REG_PROP_GAIN] = 16'(RST_PROP_GAIN);
    cfg_shadow[REG_INT_GAIN] = 16'(RST_INT_GAIN);
    cfg_shadow[REG_DER_GAIN] = 16'(RST_DER_GAIN);
    cfg_shadow[REG_LOST_THR] = 16'(RST_LOST_THR);
    cfg_shadow[REG_NEAR_THR] = 16'(RST_NEAR_THR);
    cfg_shadow[REG_FOLLOW_FLR] = 16'(RST_FOLLOW_FLR);

    // Defaults after reset: mode bands and their edges.
    plan.push_back(fixed_row(328, 1000, 1000, MODE_LOST, SPEED_CRUISE, TURN_LOST));
    plan.push_back(fixed_row(16'hffff, 16'hffff, 16'hffff, MODE_LOST, SPEED_CRUISE,
                             TURN_LOST));
    plan.push_back(fixed_row(0, 0, 0, MODE_FAST, SPEED_STOP, TURN_FAST));
    plan.push_back(tick_row(300, 500, 270));
    plan.push_back(tick_row(287, 400, 287));
    plan.push_back(tick_row(400, 300, 400));
    plan.push_back(tick_row(200, 500, 500));
    plan.push_back(tick_row(400, 369, 400));
    plan.push_back(fixed_row(400, 287, 400, MODE_FAST, SPEED_STOP, TURN_FAST));
    plan.push_back(fixed_row(300, 500, 266, MODE_LOST, SPEED_CRUISE, TURN_LOST));
    plan.push_back(tick_row(300, 500, 267));
    plan.push_back(fixed_row(370, 370, 370, MODE_LOST, SPEED_CRUISE, TURN_LOST));
    // Full-scale gains drive the PID into saturation, negated extreme included.
    plan.push_back(wr_row(REG_TARGET, 16'h0000));
    plan.push_back(wr_row(REG_PROP_GAIN, 16'hffff));
    plan.push_back(wr_row(REG_INT_GAIN, 16'hffff));
    plan.push_back(wr_row(REG_DER_GAIN, 16'hffff));
    plan.push_back(wr_row(REG_SPARE, 16'h0000));
    plan.push_back(tick_row(16'hffff, 300, 16'hffff));
    plan.push_back(tick_row(0, 300, 16'hffff));
    plan.push_back(wr_row(REG_TARGET, 16'hffff));
    plan.push_back(wr_row(REG_INT_GAIN, 16'h0000));
    plan.push_back(wr_row(REG_LOST_THR, 200));
    plan.push_back(wr_row(REG_NEAR_THR, 100));
    plan.push_back(wr_row(REG_FOLLOW_FLR, 0));
    plan.push_back(tick_row(100, 300, 50));
    // Thresholds at both ends of their range.
    plan.push_back(wr_row(REG_LOST_THR, 0));
    plan.push_back(wr_row(REG_NEAR_THR, 0));
    plan.push_back(fixed_row(0, 0, 0, MODE_FAST, SPEED_STOP, TURN_FAST));
    plan.push_back(fixed_row(1, 1, 1, MODE_LOST, SPEED_CRUISE, TURN_LOST));
    plan.push_back(wr_row(REG_LOST_THR, 16'hffff));
    plan.push_back(wr_row(REG_NEAR_THR, 16'hffff));
    plan.push_back(wr_row(REG_FOLLOW_FLR, 16'hffff));
    plan.push_back(fixed_row(16'hffff, 16'hffff, 16'hffff, MODE_FAST, SPEED_STOP,
                             TURN_FAST));
    // Zero gains leave only the rounding constant, which floors to zero.
    plan.push_back(wr_row(REG_PROP_GAIN, 16'h0000));
    plan.push_back(wr_row(REG_DER_GAIN, 16'h0000));
    plan.push_back(wr_row(REG_LOST_THR, 369));
    plan.push_back(wr_row(REG_NEAR_THR, 287));
    plan.push_back(wr_row(REG_FOLLOW_FLR, 266));
    plan.push_back(fixed_row(300, 500, 270, MODE_FOLLOW, SPEED_CRUISE, 16'sd0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].wdata);
      end else begin
        send_tick(plan[i].left, plan[i].front, plan[i].right, plan[i].typed, plan[i].want);
      end
    end

    // Random blocks, each under fresh settings and a fresh sender pace.
    for (int blk = 0; blk < 10; blk++) begin
      retune();
      tx_gap_pct = $urandom_range(0, 3) * 25;
      for (int n = 0; n < 85; n++) begin
        if ($urandom_range(0, 2) == 0) begin
          // Shaped for follow mode: right wall in the band, front clear.
          left_d = cfg_shadow[REG_NEAR_THR] + 16'($urandom_range(0, 200));
          right_d = 16'($urandom_range(cfg_shadow[REG_FOLLOW_FLR] + 16'd1,
                                       cfg_shadow[REG_NEAR_THR]));
          front_d = cfg_shadow[REG_LOST_THR] + 16'($urandom_range(1, 500));
        end else begin
          left_d = pick_dist();
          front_d = pick_dist();
          right_d = pick_dist();
        end
        send_tick(left_d, front_d, right_d, 1'b0, '0);
      end
    end

    // Back-to-back tail: drive the error sum hard downward and then upward.
    calm_tail = 1'b1;
    wait_idle();
    write_reg(REG_TARGET, 16'h0000);
    repeat (20) send_tick(16'hffff, pick_dist(), pick_dist(), 1'b0, '0);
    wait_idle();
    write_reg(REG_TARGET, 16'hffff);
    repeat (20) send_tick(16'h0000, pick_dist(), pick_dist(), 1'b0, '0);

    wait_idle();
    repeat (8) @(posedge clk);
    if (n_fail == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
